### rtl/wvnk_pkg.sv
// Shared types and constants for the weight vector neighborhood block.
// No dependencies; used by the top level and by wvnk_dist.
package wvnk_pkg;

  localparam int DEF_MAX_VECTORS    = 256;
  localparam int DEF_MAX_OBJECTIVES = 8;
  localparam int DEF_MAX_NEIGHBORS  = 32;

  localparam int WEIGHT_W       = 16;
  localparam int DIST_W         = 34;
  localparam int SQ_W           = 2 * WEIGHT_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int POP_SIZE_W   = 9;
  localparam int NEIGH_SIZE_W = 6;
  localparam int NUM_OBJ_W    = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;

  localparam int VEC_IDX_W  = 8;
  localparam int OBJ_IDX_W  = 3;
  localparam int RANK_W     = 5;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGH_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OBJ    = 2'd2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Control tag that travels with each component through the distance unit.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic mask;
  } dist_ctl_t;

endpackage

### rtl/weight_vector_neighborhood_knn.sv
// Weight vector neighborhood search: top level.
// Uses wvnk_pkg, wvnk_ram (weight and scratch stores) and wvnk_dist.
//
// Loads (tuser 0) write one weight component each. A query (tuser 1) reads
// the queried vector, then streams pop_size*num_obj components through one
// squared-distance unit (one per cycle), then runs neigh_size selection
// passes over the scratch store on its single read port, each pass handing
// its neighbor to the output register. The input is not ready while a query
// runs; the last results may still wait in the output register when the next
// transaction is accepted. Weights read before being written are undefined.
module weight_vector_neighborhood_knn #(
  parameter int MAX_VECTORS    = wvnk_pkg::DEF_MAX_VECTORS,
  parameter int MAX_OBJECTIVES = wvnk_pkg::DEF_MAX_OBJECTIVES,
  parameter int MAX_NEIGHBORS  = wvnk_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // vector_index[7:0], objective_index[10:8], weight_value[26:11], zero pad
  input  logic [wvnk_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // rank[4:0], neighbor_index[12:5], zero pad
  output logic [wvnk_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wvnk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wvnk_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int VW     = $clog2(MAX_VECTORS);
  localparam int CW     = $clog2(MAX_VECTORS + 1);
  localparam int OW     = $clog2(MAX_OBJECTIVES + 1);
  localparam int KW     = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
  localparam int NW     = $clog2(MAX_NEIGHBORS + 1);
  localparam int WDEPTH = MAX_VECTORS * MAX_OBJECTIVES;
  localparam int AW     = $clog2(WDEPTH);
  localparam int SW     = wvnk_pkg::DIST_W + VW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QLOAD,
    S_DIST,
    S_DRAIN,
    S_SEL_RD,
    S_SEL_LD,
    S_SEL_RUN,
    S_EMIT
  } state_t;

  state_t state;

  logic [wvnk_pkg::POP_SIZE_W-1:0]   pop_size;
  logic [wvnk_pkg::NEIGH_SIZE_W-1:0] neigh_size;
  logic [wvnk_pkg::NUM_OBJ_W-1:0]    num_obj;

  // input fields
  logic [wvnk_pkg::VEC_IDX_W-1:0] in_vec;
  logic [wvnk_pkg::OBJ_IDX_W-1:0] in_obj;
  logic [wvnk_pkg::WEIGHT_W-1:0]  in_weight;
  logic                           s_fire;

  // effective settings at query time
  logic [CW-1:0] pop_eff;
  logic [NW-1:0] ns_eff;
  logic [OW-1:0] kn_eff;
  logic          zero_eff;
  logic [31:0]   ns_tmp;
  logic [31:0]   nobj_tmp;
  logic          query_ok;

  // latched query settings
  logic [CW-1:0] pop_q;
  logic [NW-1:0] ns_q;
  logic [OW-1:0] kn_q;
  logic          zero_q;
  logic [AW-1:0] qbase;

  // sequencing
  logic [OW-1:0] kc;
  logic [CW-1:0] jc;
  logic [CW-1:0] jr;
  logic [NW-1:0] ic;
  logic [AW-1:0] vbase;
  logic          qcap;
  logic          rv;
  logic [KW-1:0] rk;
  logic [VW-1:0] rj;
  logic          rfirst;
  logic          rlast;

  logic [wvnk_pkg::WEIGHT_W-1:0] qv [MAX_OBJECTIVES];

  // weight store
  logic                          w_we;
  logic [AW-1:0]                 w_waddr;
  logic [AW-1:0]                 w_raddr;
  logic [wvnk_pkg::WEIGHT_W-1:0] w_rdata;

  // distance unit
  wvnk_pkg::dist_ctl_t         d_ctl;
  logic                        dist_out_v;
  logic [VW-1:0]               dist_out_idx;
  logic [wvnk_pkg::DIST_W-1:0] dist_out_d;
  logic                        dist_busy;

  // scratch store {distance, order}
  logic          s_we;
  logic [VW-1:0] s_waddr;
  logic [SW-1:0] s_wdata;
  logic [VW-1:0] s_raddr;
  logic [SW-1:0] s_rdata;
  logic [wvnk_pkg::DIST_W-1:0] rd_d;
  logic [VW-1:0]               rd_o;

  // selection
  logic [wvnk_pkg::DIST_W-1:0] cur_d;
  logic [VW-1:0]               cur_o;
  logic                        swap;
  logic                        out_free;

  logic [wvnk_pkg::RANK_W-1:0]    out_rank;
  logic [wvnk_pkg::VEC_IDX_W-1:0] out_nbr;

  assign in_vec    = s_tdata[7:0];
  assign in_obj    = s_tdata[10:8];
  assign in_weight = s_tdata[26:11];
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(pop_size) > 32'(MAX_VECTORS)) begin
      pop_eff = CW'(MAX_VECTORS);
    end else begin
      pop_eff = CW'(pop_size);
    end
    ns_tmp = 32'(neigh_size);
    if (ns_tmp > 32'(pop_eff)) begin
      ns_tmp = 32'(pop_eff);
    end
    if (ns_tmp > 32'(MAX_NEIGHBORS)) begin
      ns_tmp = 32'(MAX_NEIGHBORS);
    end
    ns_eff = NW'(ns_tmp);
    nobj_tmp = 32'(num_obj);
    if (nobj_tmp > 32'(MAX_OBJECTIVES)) begin
      nobj_tmp = 32'(MAX_OBJECTIVES);
    end
    zero_eff = (nobj_tmp == 32'd0);
    kn_eff   = zero_eff ? OW'(1) : OW'(nobj_tmp);
    query_ok = (32'(in_vec) < 32'(pop_eff)) && (ns_eff != '0);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size   <= wvnk_pkg::POP_SIZE_W'(256);
      neigh_size <= wvnk_pkg::NEIGH_SIZE_W'(20);
      num_obj    <= wvnk_pkg::NUM_OBJ_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wvnk_pkg::REG_POP_SIZE:   pop_size   <= cfg_data[wvnk_pkg::POP_SIZE_W-1:0];
        wvnk_pkg::REG_NEIGH_SIZE: neigh_size <= cfg_data[wvnk_pkg::NEIGH_SIZE_W-1:0];
        wvnk_pkg::REG_NUM_OBJ:    num_obj    <= cfg_data[wvnk_pkg::NUM_OBJ_W-1:0];
        default: ;
      endcase
    end
  end

  // weight store ports
  assign w_we = s_fire && (wvnk_pkg::cmd_t'(s_tuser) == wvnk_pkg::CMD_LOAD)
                && (32'(in_vec) < 32'(MAX_VECTORS))
                && (32'(in_obj) < 32'(MAX_OBJECTIVES));
  assign w_waddr = AW'(32'(in_vec) * MAX_OBJECTIVES + 32'(in_obj));

  always_comb begin
    if (state == S_QLOAD) begin
      w_raddr = qbase + AW'(kc);
    end else begin
      w_raddr = vbase + AW'(kc);
    end
  end

  wvnk_ram #(
    .WIDTH (wvnk_pkg::WEIGHT_W),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_weight),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  always_comb begin
    d_ctl.valid = rv;
    d_ctl.first = rfirst;
    d_ctl.last  = rlast;
    d_ctl.mask  = zero_q;
  end

  wvnk_dist #(
    .IDX_W (VW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (d_ctl),
    .in_weight (w_rdata),
    .in_query  (qv[rk]),
    .in_idx    (rj),
    .out_valid (dist_out_v),
    .out_idx   (dist_out_idx),
    .out_dist  (dist_out_d),
    .busy      (dist_busy)
  );

  // scratch store ports
  assign rd_d = s_rdata[SW-1:VW];
  assign rd_o = s_rdata[VW-1:0];
  assign swap = (cur_d > rd_d);

  always_comb begin
    if (state == S_SEL_RUN) begin
      s_we    = swap;
      s_waddr = VW'(jr);
      s_wdata = {cur_d, cur_o};
    end else begin
      s_we    = dist_out_v;
      s_waddr = dist_out_idx;
      s_wdata = {dist_out_d, dist_out_idx};
    end
    case (state)
      S_SEL_LD:  s_raddr = VW'(32'(ic) + 1);
      S_SEL_RUN: s_raddr = VW'(32'(jr) + 1);
      default:   s_raddr = VW'(ic);
    endcase
  end

  wvnk_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_VECTORS)
  ) u_scratch_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (qcap) begin
      qv[rk] <= w_rdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    rv   <= 1'b0;
    qcap <= 1'b0;
    if (m_tvalid && m_tready) begin
      m_tvalid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (s_fire && (wvnk_pkg::cmd_t'(s_tuser) == wvnk_pkg::CMD_QUERY) && query_ok) begin
          pop_q  <= pop_eff;
          ns_q   <= ns_eff;
          kn_q   <= kn_eff;
          zero_q <= zero_eff;
          qbase  <= AW'(32'(in_vec) * MAX_OBJECTIVES);
          kc     <= '0;
          state  <= S_QLOAD;
        end
      end
      S_QLOAD: begin
        qcap <= 1'b1;
        rk   <= KW'(kc);
        if (kc == kn_q - OW'(1)) begin
          kc    <= '0;
          jc    <= '0;
          vbase <= '0;
          state <= S_DIST;
        end else begin
          kc <= kc + OW'(1);
        end
      end
      S_DIST: begin
        rv     <= 1'b1;
        rk     <= KW'(kc);
        rj     <= VW'(jc);
        rfirst <= (kc == '0);
        rlast  <= (kc == kn_q - OW'(1));
        if (kc == kn_q - OW'(1)) begin
          kc    <= '0;
          vbase <= vbase + AW'(MAX_OBJECTIVES);
          jc    <= jc + CW'(1);
          if (jc == pop_q - CW'(1)) begin
            state <= S_DRAIN;
          end
        end else begin
          kc <= kc + OW'(1);
        end
      end
      S_DRAIN: begin
        if (!rv && !dist_busy) begin
          ic    <= '0;
          state <= S_SEL_RD;
        end
      end
      S_SEL_RD: begin
        state <= S_SEL_LD;
      end
      S_SEL_LD: begin
        cur_d <= rd_d;
        cur_o <= rd_o;
        jr    <= CW'(32'(ic) + 1);
        if (32'(ic) + 1 < 32'(pop_q)) begin
          state <= S_SEL_RUN;
        end else begin
          state <= S_EMIT;
        end
      end
      S_SEL_RUN: begin
        if (swap) begin
          cur_d <= rd_d;
          cur_o <= rd_o;
        end
        jr <= jr + CW'(1);
        if (32'(jr) + 1 >= 32'(pop_q)) begin
          state <= S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          m_tvalid <= 1'b1;
          out_rank <= wvnk_pkg::RANK_W'(ic);
          out_nbr  <= wvnk_pkg::VEC_IDX_W'(cur_o);
          m_tlast  <= (ic == ns_q - NW'(1));
          ic       <= ic + NW'(1);
          if (ic == ns_q - NW'(1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_SEL_RD;
          end
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state    <= S_IDLE;
      rv       <= 1'b0;
      qcap     <= 1'b0;
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {3'b000, out_nbr, out_rank};

`ifndef SYNTHESIS
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL_RUN) |-> (32'(jr) < 32'(pop_q)) && (32'(ic) < 32'(jr)))
    else $error("selection index out of range");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && m_tvalid && !m_tready |=> (state == S_EMIT) && $stable(ic))
    else $error("result emitted over a stalled output");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rv && !qcap && !dist_busy)
    else $error("input ready while distance pipeline busy");

  a_dist_write: assert property (@(posedge clk) disable iff (rst)
    dist_out_v |-> ((state == S_DIST) || (state == S_DRAIN))
                   && (32'(dist_out_idx) < 32'(pop_q)))
    else $error("distance write outside distance phase");
`endif

endmodule

### rtl/wvnk_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module wvnk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wvnk_dist.sv
// Squared-distance unit: abs difference, square, saturating accumulate.
// Uses wvnk_pkg. One component per cycle, result registered on the last one.
module wvnk_dist #(
  parameter int IDX_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wvnk_pkg::dist_ctl_t        in_ctl,
  input  logic [wvnk_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [wvnk_pkg::WEIGHT_W-1:0] in_query,
  input  logic [IDX_W-1:0]           in_idx,
  output logic                       out_valid,
  output logic [IDX_W-1:0]           out_idx,
  output logic [wvnk_pkg::DIST_W-1:0] out_dist,
  output logic                       busy
);

  wvnk_pkg::dist_ctl_t ctl1, ctl2;
  logic [IDX_W-1:0]              idx1, idx2;
  logic [wvnk_pkg::WEIGHT_W-1:0] diff1;
  logic [wvnk_pkg::SQ_W-1:0]     sq2;
  logic [wvnk_pkg::DIST_W-1:0]   acc;
  logic [wvnk_pkg::DIST_W-1:0]   acc_next;
  logic [wvnk_pkg::DIST_W:0]     sum;

  always_comb begin
    sum = {1'b0, acc} + (wvnk_pkg::DIST_W + 1)'(sq2);
    if (ctl2.first) begin
      acc_next = wvnk_pkg::DIST_W'(sq2);
    end else if (sum > (wvnk_pkg::DIST_W + 1)'(wvnk_pkg::DIST_MAX)) begin
      acc_next = wvnk_pkg::DIST_MAX;
    end else begin
      acc_next = sum[wvnk_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_weight >= in_query) begin
      diff1 <= in_weight - in_query;
    end else begin
      diff1 <= in_query - in_weight;
    end
    idx1 <= in_idx;
    ctl1 <= in_ctl;
    sq2  <= ctl1.mask ? '0 : diff1 * diff1;
    idx2 <= idx1;
    ctl2 <= ctl1;
    if (ctl2.valid) begin
      acc <= acc_next;
    end
    out_valid <= ctl2.valid && ctl2.last;
    out_idx   <= idx2;
    out_dist  <= acc_next;
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      out_valid  <= 1'b0;
    end
  end

  assign busy = ctl1.valid || ctl2.valid || out_valid;

endmodule
